// ===== design/ole_pkg.sv =====
// Shared types, constants and codes for the ordered list engine.
package ole_pkg;

  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    OP_INS_HEAD  = 3'd0,
    OP_INS_TAIL  = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_DEL_HEAD  = 3'd3,
    OP_DEL_TAIL  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_COUNT     = 3'd6,
    OP_SEARCH    = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_HOLD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_cmd_t;

endpackage

// ===== design/ole_datapath.sv =====
// Shifting cell array, count register and result register of the list engine.
module ole_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  ole_pkg::ctl_cmd_t        cmd,
  input  logic [2:0]               opcode,
  input  logic signed [31:0]       item_value,
  input  logic [6:0]               place,
  output logic [2:0]               status,
  output logic signed [31:0]       removed_value,
  output logic [6:0]               found_place,
  output logic [6:0]               length
);

  logic [31:0]             cells [ole_pkg::Capacity];
  logic [31:0]             cells_next [ole_pkg::Capacity];
  logic [ole_pkg::CntW-1:0] count, count_next;
  logic [2:0]              op_q;
  logic [31:0]             val_q;
  logic [6:0]              place_q;

  // Shift controls for the whole cell array.
  logic                    do_ins, do_del;
  logic [ole_pkg::CntW-1:0] ins_idx, del_idx;
  ole_pkg::status_t        st;
  logic [31:0]             rem;
  logic [6:0]              fnd;
  logic [ole_pkg::Capacity-1:0] hit;
  logic                    place_bad;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= opcode;
      val_q   <= item_value;
      place_q <= place;
    end
  end

  assign place_bad = (place_q == 7'd0) ||
                     ({{(ole_pkg::CntW > 7 ? ole_pkg::CntW - 7 : 0){1'b0}}, place_q} >
                      ole_pkg::CntW'(count));

  always_comb begin
    for (int i = 0; i < ole_pkg::Capacity; i++) begin
      hit[i] = (cells[i] == val_q) && (ole_pkg::CntW'(i) < count);
    end
  end

  always_comb begin
    st      = ole_pkg::ST_OK;
    rem     = 32'd0;
    fnd     = 7'd0;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_idx = '0;
    del_idx = '0;
    case (ole_pkg::opcode_t'(op_q))
      ole_pkg::OP_INS_HEAD, ole_pkg::OP_INS_TAIL, ole_pkg::OP_INS_AFTER: begin
        if (count == ole_pkg::CntW'(ole_pkg::Capacity)) begin
          st = ole_pkg::ST_FULL;
        end else if (op_q == ole_pkg::OP_INS_HEAD) begin
          do_ins = 1'b1;
        end else if (op_q == ole_pkg::OP_INS_TAIL) begin
          do_ins  = 1'b1;
          ins_idx = count;
        end else if (place_bad) begin
          st = ole_pkg::ST_BADPOS;
        end else begin
          do_ins  = 1'b1;
          ins_idx = ole_pkg::CntW'(place_q);
        end
      end
      ole_pkg::OP_DEL_HEAD, ole_pkg::OP_DEL_TAIL, ole_pkg::OP_DEL_AT: begin
        if (count == '0) begin
          st = ole_pkg::ST_EMPTY;
        end else if (op_q == ole_pkg::OP_DEL_HEAD) begin
          do_del = 1'b1;
        end else if (op_q == ole_pkg::OP_DEL_TAIL) begin
          do_del  = 1'b1;
          del_idx = count - 1'b1;
        end else if (place_bad) begin
          st = ole_pkg::ST_BADPOS;
        end else begin
          do_del  = 1'b1;
          del_idx = ole_pkg::CntW'(place_q) - 1'b1;
        end
        if (do_del) begin
          rem = cells[del_idx[ole_pkg::IdxW-1:0]];
        end
      end
      ole_pkg::OP_COUNT: begin
        st = ole_pkg::ST_OK;
      end
      default: begin
        st = ole_pkg::ST_NOTFOUND;
        // Priority pick of the lowest matching cell.
        for (int i = ole_pkg::Capacity - 1; i >= 0; i--) begin
          if (hit[i]) begin
            st  = ole_pkg::ST_OK;
            fnd = 7'(i + 1);
          end
        end
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins) count_next = count + 1'b1;
    if (do_del) count_next = count - 1'b1;
    for (int i = 0; i < ole_pkg::Capacity; i++) begin
      cells_next[i] = cells[i];
      if (do_ins) begin
        if (ole_pkg::CntW'(i) == ins_idx) begin
          cells_next[i] = val_q;
        end else if (ole_pkg::CntW'(i) > ins_idx && i > 0) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (ole_pkg::CntW'(i) >= del_idx && i < ole_pkg::Capacity - 1) begin
          cells_next[i] = cells[(i < ole_pkg::Capacity - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      cells         <= cells_next;
      status        <= st;
      removed_value <= rem;
      found_place   <= fnd;
      length        <= 7'(count_next);
    end
  end

endmodule

// ===== design/ole_controller.sv =====
// Handshake controller of the list engine.
module ole_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ole_pkg::ctl_cmd_t cmd
);

  ole_pkg::state_t state, state_next;
  logic            take;

  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ole_pkg::S_IDLE: begin
        if (take) state_next = ole_pkg::S_EXEC;
      end
      ole_pkg::S_EXEC: begin
        state_next = ole_pkg::S_HOLD;
      end
      ole_pkg::S_HOLD: begin
        if (!out_stall) state_next = take ? ole_pkg::S_EXEC : ole_pkg::S_IDLE;
      end
      default: state_next = ole_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      ole_pkg::S_IDLE: in_stall = 1'b0;
      ole_pkg::S_EXEC: cmd.exec = 1'b1;
      ole_pkg::S_HOLD: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
      end
      default: in_stall = 1'b1;
    endcase
    cmd.capture = take;
  end

endmodule

// ===== design/ordered_list_engine_unit.sv =====
// Top level of the ordered list engine: controller plus cell-array datapath.
// A command is captured on acceptance, executed in the next cycle by a single
// shift or priority compare across all 64 cells, and its result is offered in
// the cycle after that from the result register.
// A new command is accepted in the cycle its predecessor's result is taken,
// so commands never overlap in the engine. Synchronous reset empties the list;
// cell contents are not cleared and are never read unwritten.
module ordered_list_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] item_value,
  input  logic [6:0]         place,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] removed_value,
  output logic [6:0]         found_place,
  output logic [6:0]         length
);

  // Command bundle from the controller: capture the incoming transaction,
  // then execute it against the cell array.
  ole_pkg::ctl_cmd_t cmd;

  ole_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the cells, the entry count and the result register.
  // Results are held stable while the output transaction is stalled.
  ole_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .item_value    (item_value),
    .place         (place),
    .status        (status),
    .removed_value (removed_value),
    .found_place   (found_place),
    .length        (length)
  );

endmodule

// ===== design/ole_checker.sv =====
// Port-level checker for the ordered list engine, bound to the top level.
module ole_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         status,
  input logic signed [31:0] removed_value,
  input logic [6:0]         found_place,
  input logic [6:0]         length
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(length) &&
                               $stable(removed_value) && $stable(found_place))
    else $error("result changed while stalled");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length <= 7'(ole_pkg::Capacity))
    else $error("length above capacity");

  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_place != 7'd0 |-> status == ole_pkg::ST_OK && found_place <= length)
    else $error("bad found position");

  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result overlaps a new command");

endmodule

bind ordered_list_engine_unit ole_checker u_chk (.*);

// ===== verif/ordered_list_engine_unit_checker.sv =====
// Checker for the ordered list engine: watches both channels, predicts and compares.
module ordered_list_engine_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] item_value,
  input  logic [6:0]         place,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         status,
  input  logic signed [31:0] removed_value,
  input  logic [6:0]         found_place,
  input  logic [6:0]         length,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] removed;
    logic [6:0]  found;
    logic [6:0]  length;
  } list_reply_t;

  logic [31:0] shadow_list[$];
  list_reply_t reply_queue[$];

  function automatic list_reply_t apply_command(logic [2:0] op, logic [31:0] val,
                                                logic [6:0] pos);
    list_reply_t r;
    int n;
    r = '0;
    r.status = ole_pkg::ST_OK;
    n = shadow_list.size();
    case (ole_pkg::opcode_t'(op))
      ole_pkg::OP_INS_HEAD, ole_pkg::OP_INS_TAIL, ole_pkg::OP_INS_AFTER: begin
        if (n >= ole_pkg::Capacity) r.status = ole_pkg::ST_FULL;
        else if (op == ole_pkg::OP_INS_HEAD) shadow_list.push_front(val);
        else if (op == ole_pkg::OP_INS_TAIL) shadow_list.push_back(val);
        else if (pos == 0 || pos > n) r.status = ole_pkg::ST_BADPOS;
        else shadow_list.insert(pos, val);
      end
      ole_pkg::OP_DEL_HEAD, ole_pkg::OP_DEL_TAIL, ole_pkg::OP_DEL_AT: begin
        if (n == 0) r.status = ole_pkg::ST_EMPTY;
        else if (op == ole_pkg::OP_DEL_HEAD) r.removed = shadow_list.pop_front();
        else if (op == ole_pkg::OP_DEL_TAIL) r.removed = shadow_list.pop_back();
        else if (pos == 0 || pos > n) r.status = ole_pkg::ST_BADPOS;
        else begin
          r.removed = shadow_list[pos - 1];
          shadow_list.delete(pos - 1);
        end
      end
      ole_pkg::OP_COUNT: ;
      default: begin
        r.status = ole_pkg::ST_NOTFOUND;
        for (int k = 0; k < n; k++) begin
          if (shadow_list[k] == val) begin
            r.found = 7'(k + 1);
            r.status = ole_pkg::ST_OK;
            break;
          end
        end
      end
    endcase
    r.length = 7'(shadow_list.size());
    return r;
  endfunction

  assign pending = reply_queue.size();

  always @(posedge clk) begin
    list_reply_t want;
    if (rst) begin
      fail_count <= 0;
      shadow_list.delete();
      reply_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_queue.size() == 0) begin
          $display("%0t: unexpected result status=%0d len=%0d", $time, status, length);
          fail_count <= fail_count + 1;
        end else begin
          want = reply_queue.pop_front();
          if (want != {status, removed_value, found_place, length}) begin
            $display("%0t: mismatch expected st=%0d rem=%0d fnd=%0d len=%0d",
                     $time, want.status, $signed(want.removed), want.found, want.length);
            $display("%0t:          actual   st=%0d rem=%0d fnd=%0d len=%0d",
                     $time, status, removed_value, found_place, length);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        reply_queue.push_back(apply_command(opcode, item_value, place));
    end
  end
endmodule

// ===== verif/ordered_list_engine_unit_tb.sv =====
// Testbench top for the ordered list engine: stimulus, idling and verdict.
module ordered_list_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         opcode = '0;
  logic signed [31:0] item_value = '0;
  logic [6:0]         place = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic signed [31:0] removed_value;
  logic [6:0]         found_place;
  logic [6:0]         length;
  int                 fail_count;
  int                 pending;

  // Idle rates in percent for the sender and the receiver, changed per phase.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;
  // Rough model of the list size, used only to steer random commands and the fill.
  int approx_len = 0;
  // Recent inserted values, so that searches can hit.
  logic [31:0] recent_vals[$];

  ordered_list_engine_unit uut (.*);

  ordered_list_engine_unit_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random; the stall changes only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Hard limit on the run length; a hung block fails here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sends one transaction: optional idle cycles, then hold valid until accepted.
  // Valid goes low only when the next call decides to idle or drain runs, so a back-to-back
  // transaction keeps it high with one assignment per step.
  task automatic send_cmd(ole_pkg::opcode_t op, logic [31:0] val, logic [6:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    item_value <= val;
    place      <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    case (op)
      ole_pkg::OP_INS_HEAD, ole_pkg::OP_INS_TAIL, ole_pkg::OP_INS_AFTER: begin
        if (approx_len < ole_pkg::Capacity &&
            (op != ole_pkg::OP_INS_AFTER || (pos != 0 && pos <= approx_len)))
          approx_len++;
        recent_vals.push_back(val);
        if (recent_vals.size() > 16) void'(recent_vals.pop_front());
      end
      ole_pkg::OP_DEL_HEAD, ole_pkg::OP_DEL_TAIL, ole_pkg::OP_DEL_AT: begin
        if (approx_len > 0 && (op != ole_pkg::OP_DEL_AT || (pos != 0 && pos <= approx_len)))
          approx_len--;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_cmd();
    int pick;
    logic [31:0] v;
    logic [6:0] p;
    pick = $urandom_range(99);
    v = (recent_vals.size() != 0 && $urandom_range(1)) ?
        recent_vals[$urandom_range(recent_vals.size() - 1)] : $urandom();
    // Mostly valid positions, sometimes any position the field allows.
    p = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) :
        7'($urandom_range(approx_len + 1));
    if (pick < 45)
      send_cmd(ole_pkg::opcode_t'($urandom_range(2)), v, p);
    else if (pick < 80)
      send_cmd(ole_pkg::opcode_t'($urandom_range(5, 3)), v, p);
    else if (pick < 85)
      send_cmd(ole_pkg::OP_COUNT, v, p);
    else
      send_cmd(ole_pkg::OP_SEARCH, v, p);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: every command on an empty list, then extremes of the fields.
    send_cmd(ole_pkg::OP_DEL_HEAD, 32'd0, 7'd0);
    send_cmd(ole_pkg::OP_DEL_TAIL, 32'd0, 7'd0);
    send_cmd(ole_pkg::OP_DEL_AT, 32'd0, 7'd1);
    send_cmd(ole_pkg::OP_SEARCH, 32'd0, 7'd0);
    send_cmd(ole_pkg::OP_INS_AFTER, 32'd5, 7'd1);
    send_cmd(ole_pkg::OP_COUNT, 32'hFFFF_FFFF, 7'h7F);
    send_cmd(ole_pkg::OP_INS_HEAD, 32'h8000_0000, 7'd0);
    send_cmd(ole_pkg::OP_DEL_TAIL, 32'd0, 7'd0);
    send_cmd(ole_pkg::OP_INS_TAIL, 32'h7FFF_FFFF, 7'd0);
    send_cmd(ole_pkg::OP_INS_HEAD, 32'hFFFF_FFFF, 7'd0);
    send_cmd(ole_pkg::OP_INS_AFTER, 32'h0000_0000, 7'd2);
    send_cmd(ole_pkg::OP_INS_AFTER, 32'h1234_5678, 7'd0);
    send_cmd(ole_pkg::OP_INS_AFTER, 32'h1234_5678, 7'd4);
    send_cmd(ole_pkg::OP_SEARCH, 32'h7FFF_FFFF, 7'd0);
    send_cmd(ole_pkg::OP_SEARCH, 32'h5555_5555, 7'd0);
    send_cmd(ole_pkg::OP_DEL_AT, 32'd0, 7'd0);
    send_cmd(ole_pkg::OP_DEL_AT, 32'd0, 7'h7F);
    send_cmd(ole_pkg::OP_DEL_AT, 32'd0, 7'd1);
    send_cmd(ole_pkg::OP_DEL_HEAD, 32'd0, 7'd0);
    // Fill to capacity with tail inserts, overfill with every insert kind, then probe the last positions.
    while (approx_len < ole_pkg::Capacity) send_cmd(ole_pkg::OP_INS_TAIL, $urandom(), 7'd0);
    send_cmd(ole_pkg::OP_INS_HEAD, 32'd1, 7'd0);
    send_cmd(ole_pkg::OP_INS_TAIL, 32'd1, 7'd0);
    send_cmd(ole_pkg::OP_INS_AFTER, 32'd1, 7'd0);
    send_cmd(ole_pkg::OP_DEL_AT, 32'd0, 7'd64);
    send_cmd(ole_pkg::OP_INS_AFTER, 32'd2, 7'd63);
    send_cmd(ole_pkg::OP_DEL_AT, 32'd0, 7'd65);
    drain();

    // Random phases with changing idle rates.
    send_idle_pct = 11; recv_idle_pct = 84;
    repeat (120) random_cmd();
    // Sender holds off until every outstanding result has come back.
    drain();
    send_idle_pct = 84; recv_idle_pct = 11;
    repeat (120) random_cmd();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (120) random_cmd();
    drain();
    recv_idle_pct = 0;
    repeat (10) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/ole_pkg.sv
design/ole_datapath.sv
design/ole_controller.sv
design/ordered_list_engine_unit.sv
design/ole_checker.sv
verif/ordered_list_engine_unit_checker.sv
verif/ordered_list_engine_unit_tb.sv
